// File: rtl/core/leb_pkg.sv
`default_nettype none

package leb_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 64;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [CHAR_W-1:0] ERASE_RST = 8'd35;  // '#'
  localparam logic [CHAR_W-1:0] KILL_RST  = 8'd64;  // '@'
  localparam logic [CHAR_W-1:0] END_RST   = 8'd10;  // LF

  localparam logic [CFG_IDX_W-1:0] REG_ERASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic edit;     // accepted character request, not a line end
    logic start;    // accepted line end: begin replay
    logic advance;  // result taken, fetch next stored character
    logic done;     // last result taken: clear the line
  } leb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_end;   // pending request ends the line
    logic is_last;  // result on the port is the final one of the line
  } leb_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/leb_ctrl.sv
`default_nettype none

module leb_ctrl
  import leb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire leb_sts_t sts,
  output leb_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_EDIT   = 2'b01,
    S_REPLAY = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      S_EDIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.is_end) begin
            cmd.start = 1'b1;
            state_nxt = S_REPLAY;
          end else begin
            cmd.edit = 1'b1;
          end
        end
      end
      S_REPLAY: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.is_last) begin
            cmd.done  = 1'b1;
            state_nxt = S_EDIT;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_EDIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EDIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/leb_dpath.sv
`default_nettype none

module leb_dpath
  import leb_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CHAR_W-1:0]    in_char,
  input  wire logic                 in_end_of_input,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAR_W-1:0]    cfg_data,
  input  wire leb_cmd_t             cmd,
  output leb_sts_t                  sts,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      out_last_of_line,
  output logic                      out_line_empty,
  output logic                      out_chars_dropped
);

  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(LINE_DEPTH);

  logic [CHAR_W-1:0] erase_code_r, kill_code_r, end_code_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              empty_r, empty_nxt;

  logic [CHAR_W-1:0] mem [LINE_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr;
  logic [CW:0]       idx_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_code_r <= ERASE_RST;
      kill_code_r  <= KILL_RST;
      end_code_r   <= END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ERASE: erase_code_r <= cfg_data;
        REG_KILL:  kill_code_r  <= cfg_data;
        REG_END:   end_code_r   <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign sts.is_end = in_end_of_input || (in_char == end_code_r);
  assign idx_inc    = (CW + 1)'(idx_r) + 1'b1;
  assign sts.is_last = empty_r || (idx_inc == (CW + 1)'(fill_r));

  always_comb begin
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    empty_nxt = empty_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    if (cmd.edit) begin
      // priority: kill over erase over store
      if (in_char == kill_code_r) begin
        fill_nxt = '0;
      end else if (in_char == erase_code_r) begin
        if (fill_r != '0) begin
          fill_nxt = fill_r - 1'b1;
        end
      end else if (fill_r < FULL) begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.start) begin
      empty_nxt = (fill_r == '0);
      idx_nxt   = '0;
      rd_en     = 1'b1;
    end
    if (cmd.advance) begin
      // not last, so the next index is below the fill count
      idx_nxt = idx_inc[AW-1:0];
      rd_en   = 1'b1;
      rd_addr = idx_inc[AW-1:0];
    end
    if (cmd.done) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      empty_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= in_char;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_char          = empty_r ? '0 : rd_data_r;
  assign out_last_of_line  = sts.is_last;
  assign out_line_empty    = empty_r;
  assign out_chars_dropped = ovf_r;

endmodule

`default_nettype wire

// File: rtl/core/line_edit_buffer.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_char, in_end_of_input
// out      output     out_valid / out_ready  out_char, out_last_of_line,
//                                            out_line_empty, out_chars_dropped
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An edit character (store, erase, kill) updates the fill count and store directly. A line
// end fetches the first stored character into the read register, then a line of n
// characters gives n results, one per cycle while out_ready is high.
// The single read port of the line store sets the one-result-per-cycle replay.
// in_ready is low while a line is being replayed; out_ready low holds the result.
// Synchronous reset restores the default codes and empties the store; store
// contents are not cleared, so there is no clearing pass.

module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CHAR_W-1:0]    in_char,
  input  wire logic                 in_end_of_input,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CHAR_W-1:0]         out_char,
  output logic                      out_last_of_line,
  output logic                      out_line_empty,
  output logic                      out_chars_dropped,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAR_W-1:0]    cfg_data
);

  leb_cmd_t cmd;
  leb_sts_t sts;

  assign cfg_ready = 1'b1;

  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  leb_dpath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_char           (in_char),
    .in_end_of_input   (in_end_of_input),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_char          (out_char),
    .out_last_of_line  (out_last_of_line),
    .out_line_empty    (out_line_empty),
    .out_chars_dropped (out_chars_dropped)
  );

endmodule

`default_nettype wire

// File: rtl/core/leb_checker.sv
`default_nettype none

module leb_checker
  import leb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] out_char,
  input wire logic              out_last_of_line,
  input wire logic              out_line_empty
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(out_last_of_line))
    else $error("result changed while stalled");

  // no new request taken during replay
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during replay");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_empty |-> out_last_of_line && (out_char == '0))
    else $error("empty line result malformed");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_line |=> !out_valid && in_ready)
    else $error("replay did not stop after last result");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_char         (out_char),
  .out_last_of_line (out_last_of_line),
  .out_line_empty   (out_line_empty)
);

`default_nettype wire

// File: verif/line_edit_buffer_test.sv
module line_edit_buffer_test;
  import leb_pkg::*;

  localparam int unsigned DEPTH = LINE_DEPTH_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not decoded, write must be ignored
  localparam int N_DIR = 21;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
    logic              dropped;
  } line_res_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eoi;
    logic [7:0]        reps;
    logic              typed;   // res below is the whole outcome of this request
    line_res_t         res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAR_W-1:0]    in_char = '0;
  logic                 in_end_of_input = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last_of_line;
  logic                 out_line_empty;
  logic                 out_chars_dropped;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CHAR_W-1:0]    cfg_data = '0;

  // predictor state
  logic [CHAR_W-1:0] erase_code_m = ERASE_RST;
  logic [CHAR_W-1:0] kill_code_m  = KILL_RST;
  logic [CHAR_W-1:0] end_code_m   = END_RST;
  logic [CHAR_W-1:0] line_mem [DEPTH];
  int unsigned       fill_m = 0;
  logic              dropped_m = 1'b0;
  line_res_t         replay_q [$];

  int tx_idle_pct = 7;
  int rx_idle_pct = 73;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int chars_sent = 0;
  int lines_ended = 0;
  int results_checked = 0;
  int reg_writes = 0;

  line_res_t got_res, want_res;

  stim_row_t dir_rows [N_DIR] = '{
    '{8'h0A, 0, 1,  1, '{8'h00, 1, 1, 0}},  // line end straight after reset
    '{8'hFF, 1, 1,  1, '{8'h00, 1, 1, 0}},  // end of input, character ignored
    '{8'h00, 0, 1,  0, '0},
    '{8'hFF, 0, 1,  0, '0},
    '{8'h23, 0, 1,  0, '0},                 // erase takes back the 0xFF
    '{8'h41, 0, 1,  0, '0},
    '{8'h0A, 0, 1,  0, '0},
    '{8'h23, 0, 2,  0, '0},                 // erase on empty store
    '{8'h0A, 0, 1,  1, '{8'h00, 1, 1, 0}},
    '{8'h78, 0, 3,  0, '0},
    '{8'h40, 0, 1,  0, '0},                 // kill
    '{8'h7A, 0, 1,  0, '0},
    '{8'h0A, 1, 1,  0, '0},
    '{8'h71, 0, 66, 0, '0},                 // fill the store, two dropped
    '{8'h0A, 0, 1,  0, '0},
    '{8'h55, 0, 66, 0, '0},
    '{8'h40, 0, 1,  0, '0},                 // kill leaves the overflow flag set
    '{8'h0A, 0, 1,  1, '{8'h00, 1, 1, 1}},
    '{8'hAA, 0, 1,  0, '0},
    '{8'h23, 1, 1,  0, '0},                 // end of input beats erase code
    '{8'h40, 1, 1,  1, '{8'h00, 1, 1, 0}}   // and kill code, on an empty line
  };

  line_edit_buffer u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_char, .in_end_of_input,
    .out_valid, .out_ready, .out_char, .out_last_of_line,
    .out_line_empty, .out_chars_dropped,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input line_res_t got, input line_res_t want);
    mismatches++;
    if (mismatches <= 50)  // keep the log short on a badly broken build
      $display("MISMATCH @%0t %s: got ch=%h last=%b empty=%b drop=%b, %s",
               $time, what, got.ch, got.last, got.empty, got.dropped,
               $sformatf("want ch=%h last=%b empty=%b drop=%b",
                         want.ch, want.last, want.empty, want.dropped));
  endtask

  // line editor behaviour: updates the store, queues the replay on a line end
  function automatic void apply_char(input logic [CHAR_W-1:0] ch, input logic eoi,
                                     input bit keep);
    int unsigned k;
    if (eoi || ch == end_code_m) begin
      lines_ended++;
      if (fill_m == 0) begin
        if (keep) replay_q.push_back('{8'h00, 1'b1, 1'b1, dropped_m});
      end else begin
        for (k = 0; k < fill_m; k++)
          if (keep) replay_q.push_back('{line_mem[k], k + 1 == fill_m, 1'b0, dropped_m});
      end
      fill_m = 0;
      dropped_m = 1'b0;
    end else if (ch == kill_code_m) begin
      fill_m = 0;
    end else if (ch == erase_code_m) begin
      if (fill_m != 0) fill_m--;
    end else if (fill_m < DEPTH) begin
      line_mem[fill_m] = ch;
      fill_m++;
    end else begin
      dropped_m = 1'b1;
    end
  endfunction

  // called at a clock edge; leaves in_valid high after the request is taken
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eoi, input bit keep);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_char <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_char(ch, eoi, keep);
    chars_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ERASE: erase_code_m = val;
      REG_KILL:  kill_code_m = val;
      REG_END:   end_code_m = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_codes(input logic [CHAR_W-1:0] er, input logic [CHAR_W-1:0] kl,
                           input logic [CHAR_W-1:0] en);
    write_reg(REG_SPARE, 8'($urandom));
    write_reg(REG_ERASE, er);
    write_reg(REG_KILL, kl);
    write_reg(REG_END, en);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_lines();
    in_valid <= 1'b0;
    while (replay_q.size() != 0) @(posedge clk);
    // an edit request produces nothing, allow it to retire
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed lines: content with some edits, closed by a terminator
  task automatic send_random_line();
    int unsigned len, k, pick;
    logic [CHAR_W-1:0] ch;
    len = ($urandom_range(9) == 0) ? $urandom_range(30, 20) : $urandom_range(10);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) ch = erase_code_m;
      else if (pick < 13) ch = kill_code_m;
      else ch = 8'($urandom);
      send_char(ch, 1'b0, 1'b1);
    end
    if ($urandom_range(3) == 0) send_char(8'($urandom), 1'b1, 1'b1);
    else send_char(end_code_m, 1'b0, 1'b1);
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    stop_at = chars_sent + n_items;
    while (chars_sent < stop_at) send_random_line();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res = '{out_char, out_last_of_line, out_line_empty, out_chars_dropped};
      if (replay_q.size() == 0) begin
        report_mismatch("result with nothing pending", got_res, '0);
      end else begin
        want_res = replay_q.pop_front();
        if (got_res.ch !== want_res.ch || got_res.last !== want_res.last ||
            got_res.empty !== want_res.empty || got_res.dropped !== want_res.dropped)
          report_mismatch("wrong result", got_res, want_res);
        results_checked++;
      end
    end
  end

  initial begin
    int r, n;
    logic [CHAR_W-1:0] v, w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset codes in force
    for (r = 0; r < N_DIR; r++) begin
      for (n = 0; n < dir_rows[r].reps; n++) begin
        send_char(dir_rows[r].ch, dir_rows[r].eoi, !dir_rows[r].typed);
        if (dir_rows[r].typed) replay_q.push_back(dir_rows[r].res);
      end
    end

    drain_lines();
    set_codes(8'h00, 8'hFF, END_RST);
    long_hold_req <= 1'b1;
    random_phase(16);

    drain_lines();
    v = 8'($urandom);
    set_codes(v, v, v);  // all codes equal: line end wins
    tx_idle_pct = 73;
    rx_idle_pct <= 7;
    random_phase(16);

    drain_lines();
    v = 8'($urandom);
    w = v ^ 8'($urandom_range(255, 1));
    set_codes(v, v, w);  // kill wins over erase
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    random_phase(16);

    drain_lines();
    repeat (8) @(posedge clk);
    $display("line_edit_buffer_test: %0d characters sent, %0d lines ended, %0d results checked",
             chars_sent, lines_ended, results_checked);
    $display("line_edit_buffer_test: %0d register writes, receiver held off for %0d cycles once",
             reg_writes, LONG_HOLD);
    if (mismatches == 0)
      $display("line_edit_buffer_test: done, clean");
    else
      $display("line_edit_buffer_test: done, errors");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("line_edit_buffer_test: timeout");
    $display("line_edit_buffer_test: done, errors");
    $finish;
  end

endmodule

// File: line_edit_buffer.f
rtl/core/leb_pkg.sv
rtl/core/leb_ctrl.sv
rtl/core/leb_dpath.sv
rtl/core/line_edit_buffer.sv
rtl/core/leb_checker.sv
verif/line_edit_buffer_test.sv
